FILE: rtl/ripq_pkg.sv
// ----------------------------------------------------------------------------
// ripq_pkg
// Commands, result codes and channel payloads shared by the read-index
// pending queue and its channel interfaces.
// ----------------------------------------------------------------------------
package ripq_pkg;

   // Peers whose acks are recorded; acks from higher slots set no bit.
   localparam int NODE_SLOTS = 8;
   localparam int ACK_W      = 8;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_ADVANCE = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ADDED        = 3'd0,
      ST_DUPLICATE    = 3'd1,
      ST_FULL_DROPPED = 3'd2,
      ST_ACK_RECORDED = 3'd3,
      ST_ACK_UNKNOWN  = 3'd4,
      ST_RELEASED     = 3'd5,
      ST_NOT_FOUND    = 3'd6,
      ST_CLEARED      = 3'd7
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] key;
      logic [63:0] read_index;
      logic [31:0] request_tag;
      logic [2:0]  node;
   } req_payload_type;

   typedef struct packed {
      status_type       status;
      logic [63:0]      entry_key;
      logic [63:0]      entry_index;
      logic [31:0]      entry_tag;
      logic [ACK_W-1:0] ack_bits;
      logic             last;
      logic [4:0]       pending_count;
      logic [63:0]      newest_key;
      logic             queue_empty;
   } rsp_payload_type;

endpackage

FILE: rtl/ripq_if.sv
// ----------------------------------------------------------------------------
// ripq channel interfaces
// Valid/ready channels for commands and results of the pending queue.
// ----------------------------------------------------------------------------
interface ripq_req_if;
   logic                       valid;
   logic                       ready;
   ripq_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ripq_rsp_if;
   logic                       valid;
   logic                       ready;
   ripq_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/read_index_pending_queue_top.sv
// ----------------------------------------------------------------------------
// read_index_pending_queue_top
// Ordered queue of pending read requests held in one slot memory, searched
// by key one slot per cycle with a pipelined read.
// ----------------------------------------------------------------------------
// Add, ack and advance scan the pending entries, one per cycle, before their
// first result; an advance then reads and emits each released entry in turn
// (S_REL_RD, then S_REL_OUT). Clear goes straight to its result.
// One command is in work at a time; the slot memory read port sets the pace.
// Reset clears the pointers, count and handshake state; slot contents are not
// cleared, since only slots holding pending entries are ever read.
module read_index_pending_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 64
) (
   input  logic            clock,
   input  logic            reset,
   ripq_req_if.sink        req_if,
   ripq_rsp_if.source      rsp_if
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KEY_BITS-1:0]        key;
      logic [63:0]                read_index;
      logic [31:0]                tag;
      logic [ripq_pkg::ACK_W-1:0] ack;
   } slot_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_REL_RD,
      S_REL_OUT,
      S_EMIT
   } state_type;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] slot);
      next_slot = (slot == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
   endfunction

   slot_type slot_mem [QUEUE_DEPTH];
   slot_type mem_q_ff;

   state_type state_ff;

   logic [ADDR_W-1:0]   head_ff, tail_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [KEY_BITS-1:0] newest_ff;

   ripq_pkg::cmd_type   cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [63:0]         idx_ff;
   logic [31:0]         tag_ff;
   logic [2:0]          node_ff;

   logic [CNT_W-1:0]    iss_pos_ff, rd_pos_ff, rel_pos_ff, hit_pos_ff;
   logic [ADDR_W-1:0]   iss_slot_ff, rd_slot_ff, rel_slot_ff;
   logic                rd_vld_ff;

   ripq_pkg::status_type       res_status_ff;
   logic [KEY_BITS-1:0]        res_key_ff;
   logic [63:0]                res_idx_ff;
   logic [31:0]                res_tag_ff;
   logic [ripq_pkg::ACK_W-1:0] res_ack_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   ripq_pkg::rsp_payload_type  rsp_pl_ff;

   logic                       hit, iss_done, out_free, full;
   logic                       mem_re, mem_we;
   logic [ADDR_W-1:0]          mem_raddr, mem_waddr;
   slot_type                   mem_wdata;
   logic [ripq_pkg::ACK_W-1:0] ack_new;

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_pl_ff;

   always_comb begin
      hit      = rd_vld_ff && (mem_q_ff.key == key_ff);
      iss_done = (iss_pos_ff == count_ff);
      out_free = !rsp_valid_ff || rsp_if.ready;
      full     = (count_ff == CNT_W'(QUEUE_DEPTH));
      ack_new  = mem_q_ff.ack;
      if (32'(node_ff) < ripq_pkg::NODE_SLOTS) begin
         ack_new = mem_q_ff.ack | (ripq_pkg::ACK_W'(1) << node_ff);
      end

      // The result register loads whenever an emitting state finds it free.
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (out_free && (state_ff == S_REL_OUT || state_ff == S_EMIT)) begin
         rsp_valid_in = 1'b1;
      end

      mem_re    = 1'b0;
      mem_raddr = iss_slot_ff;
      mem_we    = 1'b0;
      mem_waddr = tail_ff;
      mem_wdata = '{key: key_ff, read_index: idx_ff, tag: tag_ff, ack: '0};

      if (state_ff == S_SEARCH) begin
         // Keep one read in flight per cycle until a match or the tail.
         mem_re = !hit && !iss_done;
         if (hit && cmd_ff == ripq_pkg::CMD_ACK) begin
            mem_we        = 1'b1;
            mem_waddr     = rd_slot_ff;
            mem_wdata     = mem_q_ff;
            mem_wdata.ack = ack_new;
         end else if (!hit && iss_done && cmd_ff == ripq_pkg::CMD_ADD && !full) begin
            mem_we = 1'b1;
         end
      end else if (state_ff == S_REL_RD) begin
         mem_re    = 1'b1;
         mem_raddr = rel_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= slot_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         newest_ff    <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= mem_re;
         rd_pos_ff    <= iss_pos_ff;
         rd_slot_ff   <= iss_slot_ff;

         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  cmd_ff      <= req_if.payload.cmd;
                  key_ff      <= req_if.payload.key[KEY_BITS-1:0];
                  idx_ff      <= req_if.payload.read_index;
                  tag_ff      <= req_if.payload.request_tag;
                  node_ff     <= req_if.payload.node;
                  iss_pos_ff  <= '0;
                  iss_slot_ff <= head_ff;
                  if (req_if.payload.cmd == ripq_pkg::CMD_CLEAR) begin
                     head_ff       <= '0;
                     tail_ff       <= '0;
                     count_ff      <= '0;
                     newest_ff     <= '0;
                     res_status_ff <= ripq_pkg::ST_CLEARED;
                     res_key_ff    <= '0;
                     res_idx_ff    <= '0;
                     res_tag_ff    <= '0;
                     res_ack_ff    <= '0;
                     state_ff      <= S_EMIT;
                  end else begin
                     state_ff <= S_SEARCH;
                  end
               end
            end

            S_SEARCH: begin
               if (mem_re) begin
                  iss_pos_ff  <= iss_pos_ff + 1'b1;
                  iss_slot_ff <= next_slot(iss_slot_ff);
               end
               if (hit) begin
                  res_key_ff <= key_ff;
                  res_idx_ff <= mem_q_ff.read_index;
                  res_tag_ff <= mem_q_ff.tag;
                  res_ack_ff <= (cmd_ff == ripq_pkg::CMD_ACK) ? ack_new : mem_q_ff.ack;
                  case (cmd_ff)
                     ripq_pkg::CMD_ADD: begin
                        res_status_ff <= ripq_pkg::ST_DUPLICATE;
                        state_ff      <= S_EMIT;
                     end
                     ripq_pkg::CMD_ACK: begin
                        res_status_ff <= ripq_pkg::ST_ACK_RECORDED;
                        state_ff      <= S_EMIT;
                     end
                     default: begin
                        // Advance: the pointers move now, so every release
                        // transfer already reports the final count.
                        rel_slot_ff <= head_ff;
                        rel_pos_ff  <= '0;
                        hit_pos_ff  <= rd_pos_ff;
                        head_ff     <= next_slot(rd_slot_ff);
                        count_ff    <= count_ff - (rd_pos_ff + 1'b1);
                        if (count_ff == rd_pos_ff + 1'b1) begin
                           newest_ff <= '0;
                        end
                        state_ff <= S_REL_RD;
                     end
                  endcase
               end else if (iss_done) begin
                  res_key_ff <= key_ff;
                  res_ack_ff <= '0;
                  state_ff   <= S_EMIT;
                  case (cmd_ff)
                     ripq_pkg::CMD_ADD: begin
                        if (full) begin
                           res_status_ff <= ripq_pkg::ST_FULL_DROPPED;
                           res_idx_ff    <= '0;
                           res_tag_ff    <= '0;
                        end else begin
                           res_status_ff <= ripq_pkg::ST_ADDED;
                           res_idx_ff    <= idx_ff;
                           res_tag_ff    <= tag_ff;
                           tail_ff       <= next_slot(tail_ff);
                           count_ff      <= count_ff + 1'b1;
                           newest_ff     <= key_ff;
                        end
                     end
                     ripq_pkg::CMD_ACK: begin
                        res_status_ff <= ripq_pkg::ST_ACK_UNKNOWN;
                        res_idx_ff    <= '0;
                        res_tag_ff    <= '0;
                     end
                     default: begin
                        res_status_ff <= ripq_pkg::ST_NOT_FOUND;
                        res_idx_ff    <= '0;
                        res_tag_ff    <= '0;
                     end
                  endcase
               end
            end

            S_REL_RD: begin
               state_ff <= S_REL_OUT;
            end

            S_REL_OUT: begin
               if (out_free) begin
                  rsp_pl_ff.status          <= ripq_pkg::ST_RELEASED;
                  rsp_pl_ff.entry_key       <= 64'(mem_q_ff.key);
                  rsp_pl_ff.entry_index     <= mem_q_ff.read_index;
                  rsp_pl_ff.entry_tag       <= mem_q_ff.tag;
                  rsp_pl_ff.ack_bits        <= mem_q_ff.ack;
                  rsp_pl_ff.last            <= (rel_pos_ff == hit_pos_ff);
                  rsp_pl_ff.pending_count   <= 5'(count_ff);
                  rsp_pl_ff.newest_key      <= 64'(newest_ff);
                  rsp_pl_ff.queue_empty     <= (count_ff == '0);
                  if (rel_pos_ff == hit_pos_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     rel_pos_ff  <= rel_pos_ff + 1'b1;
                     rel_slot_ff <= next_slot(rel_slot_ff);
                     state_ff    <= S_REL_RD;
                  end
               end
            end

            S_EMIT: begin
               if (out_free) begin
                  rsp_pl_ff.status          <= res_status_ff;
                  rsp_pl_ff.entry_key       <= 64'(res_key_ff);
                  rsp_pl_ff.entry_index     <= res_idx_ff;
                  rsp_pl_ff.entry_tag       <= res_tag_ff;
                  rsp_pl_ff.ack_bits        <= res_ack_ff;
                  rsp_pl_ff.last            <= 1'b1;
                  rsp_pl_ff.pending_count   <= 5'(count_ff);
                  rsp_pl_ff.newest_key      <= 64'(newest_ff);
                  rsp_pl_ff.queue_empty     <= (count_ff == '0);
                  state_ff                  <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
